// File: rtl/core/silurq_pkg.sv
// ============================================================================
// silurq_pkg: shared types and constants of the int8 SiLU table requantizer
// Configuration register codes, the configuration bundle and fixed widths.
// ============================================================================
package silurq_pkg;

	localparam int TableDepth = 256;
	localparam int TableAw    = $clog2(TableDepth);
	localparam int EntryW     = 8;

	localparam int ProdW  = 18;
	localparam int ScaleW = 50;
	localparam int AccW   = 64;

	localparam logic [5:0] ShiftMin    = 6'd2;
	localparam logic [5:0] ShiftMax    = 6'd62;
	localparam logic [5:0] DrMinShift  = 6'd31;
	localparam int         DrTermShift = 30;

	localparam logic signed [31:0] MultReset  = 32'sd1073741824;
	localparam logic [5:0]         ShiftReset = 6'd30;

	typedef enum logic [2:0] {
		REG_DIRECT_ZP  = 3'd0,
		REG_TABLE_ZP   = 3'd1,
		REG_MULTIPLIER = 3'd2,
		REG_SHIFT      = 3'd3,
		REG_OUT_ZP     = 3'd4,
		REG_DR_ENABLE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [7:0]  direct_zp;
		logic signed [7:0]  table_zp;
		logic signed [31:0] multiplier;
		logic [5:0]         shift;
		logic signed [7:0]  out_zp;
		logic               dr_enable;
	} cfg_t;

endpackage

// File: rtl/core/silurq_ram.sv
// ============================================================================
// silurq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ============================================================================
module silurq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/silurq_cfg.sv
// ============================================================================
// silurq_cfg: configuration register file
// Holds zero points and rescale settings; the shift is clamped to 2..62 on write.
// ============================================================================
module silurq_cfg import silurq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  index,
	input  logic [31:0] data,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [5:0] shift_wr;

	always_comb begin
		shift_wr = data[5:0];
		if (shift_wr < ShiftMin) begin
			shift_wr = ShiftMin;
		end else if (shift_wr > ShiftMax) begin
			shift_wr = ShiftMax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direct_zp  <= '0;
			cfg_q.table_zp   <= '0;
			cfg_q.multiplier <= MultReset;
			cfg_q.shift      <= ShiftReset;
			cfg_q.out_zp     <= '0;
			cfg_q.dr_enable  <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(index))
				REG_DIRECT_ZP:  cfg_q.direct_zp  <= data[7:0];
				REG_TABLE_ZP:   cfg_q.table_zp   <= data[7:0];
				REG_MULTIPLIER: cfg_q.multiplier <= data;
				REG_SHIFT:      cfg_q.shift      <= shift_wr;
				REG_OUT_ZP:     cfg_q.out_zp     <= data[7:0];
				REG_DR_ENABLE:  cfg_q.dr_enable  <= data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/silurq_rescale.sv
// ============================================================================
// silurq_rescale: multiply-round-shift rescale and int8 output saturation
// Four stages: scale multiply, rounding add, shift with int32 clamp, zero point
// add with int8 clamp into the output register.
// ============================================================================
module silurq_rescale import silurq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [ProdW-1:0] prod,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [7:0]       result
);

	logic                     v_s3, v_s4, v_s5, v_s6;
	logic                     en_s3, en_s4, en_s5, en_s6;
	logic signed [ScaleW-1:0] m_s3;
	logic                     nonneg_s3;
	logic signed [AccW-1:0]   sum_s4;
	logic signed [31:0]       sh_s5;
	logic signed [7:0]        res_s6;

	logic signed [AccW-1:0]   round_term;
	logic signed [AccW-1:0]   shifted;
	logic signed [31:0]       sh_clamp;
	logic signed [32:0]       zp_sum;
	logic signed [7:0]        res_clamp;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_comb begin
		round_term = AccW'(64'sd1) <<< (cfg.shift - 6'd1);
		if (cfg.dr_enable && cfg.shift > DrMinShift) begin
			if (nonneg_s3) begin
				round_term = round_term + (AccW'(64'sd1) <<< DrTermShift);
			end else begin
				round_term = round_term - (AccW'(64'sd1) <<< DrTermShift);
			end
		end
	end

	always_comb begin
		shifted = sum_s4 >>> cfg.shift;
		if (shifted > AccW'(64'sd2147483647)) begin
			sh_clamp = 32'sh7fffffff;
		end else if (shifted < -AccW'(64'sd2147483648)) begin
			sh_clamp = 32'sh80000000;
		end else begin
			sh_clamp = shifted[31:0];
		end
	end

	always_comb begin
		zp_sum = 33'(sh_s5) + 33'(cfg.out_zp);
		if (zp_sum > 33'sd127) begin
			res_clamp = 8'sd127;
		end else if (zp_sum < -33'sd128) begin
			res_clamp = -8'sd128;
		end else begin
			res_clamp = zp_sum[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			m_s3      <= ScaleW'(prod) * ScaleW'(cfg.multiplier);
			nonneg_s3 <= !prod[ProdW-1];
		end
		if (en_s4) begin
			sum_s4 <= AccW'(m_s3) + round_term;
		end
		if (en_s5) begin
			sh_s5 <= sh_clamp;
		end
		if (en_s6) begin
			res_s6 <= res_clamp;
		end
	end

	assign out_valid = v_s6;
	assign result    = res_s6;

endmodule

// File: rtl/core/int8_silu_table_requantizer.sv
// ============================================================================
// int8_silu_table_requantizer: quantized SiLU with a loadable sigmoid table
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd, sample, entry_index. cmd 1 writes
// sample into the sigmoid table at entry_index and gives no result; cmd 0
// evaluates sample and gives one activation_out item on the output channel
// (out_valid/out_ready). Every table entry an evaluation reads must have been
// written first.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no item is in flight. Unknown indexes are ignored.
// Pipeline: six register stages (table read, zero point product, scale multiply,
// rounding add, shift and int32 clamp, int8 output register). Throughput: one
// item per cycle while the receiver keeps out_ready high, set by one table
// access per item and one multiplier in each multiply stage.
// Reset clears all stage valid bits and loads the register defaults; the table
// keeps no reset value. When the receiver stalls, each stage holds only if the
// stage after it is full, so bubbles close up and in_ready drops only once all
// stages hold items.
// ============================================================================
module int8_silu_table_requantizer import silurq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic signed [7:0] sample,
	input  logic [7:0]        entry_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] activation_out,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	cfg_t                    cfg;
	logic                    en_s1, en_s2;
	logic                    v_s1, v_s2;
	logic signed [8:0]       a_s1;
	logic signed [ProdW-1:0] prod_s2;
	logic [EntryW-1:0]       entry_rd;
	logic signed [8:0]       b_diff;
	logic                    rs_ready;
	logic                    tbl_we;
	logic [TableAw-1:0]      tbl_raddr;

	assign cfg_ready = 1'b1;

	silurq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign en_s2    = !v_s2 || rs_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// sample + 128 modulo 256 is the sample with its sign bit flipped
	assign tbl_we    = in_valid && in_ready && cmd;
	assign tbl_raddr = {~sample[7], sample[6:0]};

	silurq_ram #(
		.WIDTH (EntryW),
		.DEPTH (TableDepth)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_index),
		.wdata (sample),
		.re    (en_s1),
		.raddr (tbl_raddr),
		.rdata (entry_rd)
	);

	assign b_diff = 9'(signed'(entry_rd)) - 9'(cfg.table_zp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid && !cmd;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1 <= 9'(sample) - 9'(cfg.direct_zp);
		end
		if (en_s2) begin
			prod_s2 <= ProdW'(a_s1) * ProdW'(b_diff);
		end
	end

	silurq_rescale u_rescale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (v_s2),
		.in_ready  (rs_ready),
		.prod      (prod_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (activation_out)
	);

`ifndef SYNTHESIS
	a_write_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd |=> !v_s1)
		else $error("table write entered the pipeline");

	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cmd |=> v_s1)
		else $error("evaluate item lost at stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en_s2 |=> v_s1 && $stable(a_s1) && $stable(entry_rd))
		else $error("stalled stage 1 changed");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 || !v_s2 |-> in_ready)
		else $error("input blocked with room in front stages");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.shift >= ShiftMin && cfg.shift <= ShiftMax)
		else $error("rescale shift out of range");
`endif

endmodule
